### rtl/core/sobel_gradient_magnitude_top_defines.svh
// assertion macros for the sobel gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define SGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgm assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define SGM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgm assertion failed");
`else
`define SGM_ASSERT_IMP(lbl, ante, cons)
`define SGM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/sgm_pkg.sv
package sgm_pkg;

	// fixed field widths
	localparam int GRAD_W = 11;
	localparam int MAG_W  = 15;
	localparam int CFG_W  = 12;
	localparam int ROW_W  = 13;
	localparam int IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_BORDER_MODE  = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [CFG_W-1:0] MIN_DIM          = 12'd3;

	// input item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// border modes
	localparam logic BORDER_REPEAT = 1'b0;
	localparam logic BORDER_ZERO   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQUARE,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic square;
		logic root_init;
		logic root_step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic has_res;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

### rtl/core/sgm_ram.sv
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/sgm_ctrl.sv
module sgm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  sgm_pkg::status_t stat,
	output sgm_pkg::cmd_t    cmd
);

	sgm_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				if (pix_valid && !stat.drop) state_nx = sgm_pkg::ST_LOAD;
			end
			sgm_pkg::ST_LOAD: begin
				state_nx = stat.has_res ? sgm_pkg::ST_SQUARE : sgm_pkg::ST_IDLE;
			end
			sgm_pkg::ST_SQUARE:    state_nx = sgm_pkg::ST_ROOT_INIT;
			sgm_pkg::ST_ROOT_INIT: state_nx = sgm_pkg::ST_ROOT;
			sgm_pkg::ST_ROOT: begin
				if (stat.root_last) state_nx = sgm_pkg::ST_DONE;
			end
			sgm_pkg::ST_DONE: begin
				if (stat.out_free) state_nx = sgm_pkg::ST_IDLE;
			end
			default: state_nx = sgm_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		pix_ready = 1'b0;
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				pix_ready = 1'b1;
				cmd.accept = pix_valid;
			end
			sgm_pkg::ST_LOAD:      cmd.load = 1'b1;
			sgm_pkg::ST_SQUARE:    cmd.square = 1'b1;
			sgm_pkg::ST_ROOT_INIT: cmd.root_init = 1'b1;
			sgm_pkg::ST_ROOT:      cmd.root_step = 1'b1;
			sgm_pkg::ST_DONE:      cmd.push = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/sgm_datapath.sv
module sgm_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sgm_pkg::cmd_t                    cmd,
	output sgm_pkg::status_t                 stat,
	input  logic                             kind,
	input  logic [PIXEL_BITS-1:0]            pixel,
	input  logic                             cfg_we,
	input  logic [sgm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [sgm_pkg::GRAD_W-1:0] grad_x,
	output logic signed [sgm_pkg::GRAD_W-1:0] grad_y,
	output logic [sgm_pkg::MAG_W-1:0]        magnitude_q4,
	output logic                             row_end,
	output logic                             frame_end
);

	localparam int P     = PIXEL_BITS;
	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W = (AW + 1 > sgm_pkg::CFG_W) ? AW + 1 : sgm_pkg::CFG_W;
	localparam int GW    = P + 3;
	localparam int SQ_W  = 2 * GW;
	localparam int RW    = P + 7;
	localparam int RAD_W = 2 * RW;
	localparam int RCW   = $clog2(RW);

	// configuration registers
	logic [sgm_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	logic                      border_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sgm_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sgm_pkg::FRAME_HEIGHT_RST;
			border_mode_q  <= sgm_pkg::BORDER_REPEAT;
		end else if (cfg_we) begin
			case (cfg_index)
				sgm_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				sgm_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				sgm_pkg::REG_BORDER_MODE:  border_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamped frame dimensions
	logic [CMP_W-1:0]           w_eff, w_last;
	logic [sgm_pkg::ROW_W-1:0]  h_ext, h_p1;

	always_comb begin
		if (frame_width_q < sgm_pkg::MIN_DIM) begin
			w_eff = CMP_W'(sgm_pkg::MIN_DIM);
		end else if (CMP_W'(frame_width_q) > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(frame_width_q);
		end
		w_last = w_eff - CMP_W'(1);
		h_ext = (frame_height_q < sgm_pkg::MIN_DIM) ? sgm_pkg::ROW_W'(sgm_pkg::MIN_DIM)
			: sgm_pkg::ROW_W'(frame_height_q);
		h_p1 = h_ext + sgm_pkg::ROW_W'(1);
	end

	function automatic logic [P-1:0] pad(input logic [P-1:0] v, input logic mode);
		return (mode == sgm_pkg::BORDER_ZERO) ? '0 : v;
	endfunction

	// position counters
	logic [AW-1:0]             col_q;
	logic [sgm_pkg::ROW_W-1:0] row_q;
	logic                      drain, wrap, edge_res, ctr_res, col_last, first_col;

	assign drain     = row_q >= h_ext;
	assign wrap      = row_q >= h_p1;
	assign edge_res  = (col_q == '0) && (row_q >= sgm_pkg::ROW_W'(2)) && (row_q <= h_p1);
	assign ctr_res   = !wrap && (col_q != '0) && (row_q != '0);
	assign col_last  = CMP_W'(col_q) >= w_last;
	assign first_col = col_q == AW'(1);

	// captured pixel of the accepted transaction
	logic [P-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) pix_q <= pixel;
	end

	// line stores
	logic [P-1:0] upper_rd, lower_rd;
	logic [P-1:0] mid, top, bot;
	logic         ram_we;

	assign ram_we = cmd.load && !wrap;

	sgm_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (mid),
		.re    (cmd.accept),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	sgm_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (bot),
		.re    (cmd.accept),
		.raddr (col_q),
		.rdata (lower_rd)
	);

	// new window column
	assign mid = lower_rd;
	assign top = (row_q >= sgm_pkg::ROW_W'(2)) ? upper_rd : pad(mid, border_mode_q);
	assign bot = drain ? pad(mid, border_mode_q) : pix_q;

	// window, rows top to bottom, columns oldest to newest
	logic [P-1:0] win_q [3][3];
	logic [P-1:0] lc [3];
	logic [P-1:0] cc [3];
	logic [P-1:0] rc [3];
	logic [P-1:0] nc [3];

	assign nc[0] = top;
	assign nc[1] = mid;
	assign nc[2] = bot;

	// columns for the gradient, from the window before the shift
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cc[k] = win_q[k][2];
			lc[k] = (!edge_res && first_col) ? pad(cc[k], border_mode_q) : win_q[k][1];
			rc[k] = edge_res ? pad(cc[k], border_mode_q) : nc[k];
		end
	end

	function automatic logic signed [GW-1:0] wsum(input logic [P-1:0] a,
		input logic [P-1:0] b, input logic [P-1:0] c);
		logic signed [GW-1:0] ea, eb, ec;
		ea = $signed({3'b000, a});
		eb = $signed({3'b000, b});
		ec = $signed({3'b000, c});
		return ea + (eb <<< 1) + ec;
	endfunction

	logic signed [GW-1:0] gx_c, gy_c;

	assign gx_c = wsum(rc[0], rc[1], rc[2]) - wsum(lc[0], lc[1], lc[2]);
	assign gy_c = wsum(lc[2], cc[2], rc[2]) - wsum(lc[0], cc[0], rc[0]);

	// window shift and counter advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) win_q[k][j] <= '0;
			end
		end else if (cmd.load) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
					win_q[k][2] <= nc[k];
				end
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + sgm_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// gradient and flags of the pending result
	logic signed [GW-1:0] gx_q, gy_q;
	logic                 row_end_q, frame_end_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gx_q        <= gx_c;
			gy_q        <= gy_c;
			row_end_q   <= edge_res;
			frame_end_q <= edge_res && (row_q == h_p1);
		end
	end

	// squares, operands widened before the multiply
	logic [SQ_W-1:0] sqx_q, sqy_q;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= $unsigned(SQ_W'(gx_q) * SQ_W'(gx_q));
			sqy_q <= $unsigned(SQ_W'(gy_q) * SQ_W'(gy_q));
		end
	end

	// square root, one result bit per cycle
	logic [RAD_W-1:0] rad_q;
	logic [RW+1:0]    rem_q, rem_sh, trial;
	logic [RW-1:0]    root_q;
	logic [RCW-1:0]   cnt_q;
	logic [SQ_W-1:0]  sq_sum;

	assign sq_sum = sqx_q + sqy_q;
	assign rem_sh = {rem_q[RW-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rad_q  <= RAD_W'(sq_sum) << 8;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			cnt_q <= cnt_q + RCW'(1);
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.push) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			grad_x       <= gx_q[sgm_pkg::GRAD_W-1:0];
			grad_y       <= gy_q[sgm_pkg::GRAD_W-1:0];
			magnitude_q4 <= root_q[sgm_pkg::MAG_W-1:0];
			row_end      <= row_end_q;
			frame_end    <= frame_end_q;
		end
	end

	// status back to the controller
	assign stat.drop      = (kind == sgm_pkg::KIND_FLUSH) && !drain;
	assign stat.has_res   = edge_res || ctr_res;
	assign stat.root_last = cnt_q == RCW'(RW - 1);
	assign stat.out_free  = !res_valid || res_ready;

endmodule

### rtl/core/sobel_gradient_magnitude_top.sv
// channel   | handshake               | payload
// pixel in  | pix_valid / pix_ready   | kind, pixel
// result    | res_valid / res_ready   | grad_x, grad_y, magnitude_q4, row_end, frame_end
// config    | cfg_we                  | cfg_index, cfg_wdata
//
// a transaction with no result only loads; one with a result then runs square,
// root init, the bit-serial square root and done, which waits for a free output
// a flush tick during pixel rows is dropped in its accept cycle
// reset clears counters, window and config; line stores need no clearing
// a finished result waits in the output register while the next transaction is taken

`include "sobel_gradient_magnitude_top_defines.svh"

module sobel_gradient_magnitude_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic                              kind,
	input  logic [PIXEL_BITS-1:0]             pixel,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic signed [sgm_pkg::GRAD_W-1:0] grad_x,
	output logic signed [sgm_pkg::GRAD_W-1:0] grad_y,
	output logic [sgm_pkg::MAG_W-1:0]         magnitude_q4,
	output logic                              row_end,
	output logic                              frame_end,
	input  logic                              cfg_we,
	input  logic [sgm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]         cfg_wdata
);

	sgm_pkg::cmd_t    cmd;
	sgm_pkg::status_t stat;

	// sequencer
	sgm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// window, gradients and root
	sgm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.pixel        (pixel),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.magnitude_q4 (magnitude_q4),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	// checks
	`SGM_ASSERT_IMP(a_no_overwrite, cmd.push, !res_valid || res_ready)
	`SGM_ASSERT_NEXT(a_drop_stays_ready, pix_valid && pix_ready && stat.drop, pix_ready)
	`SGM_ASSERT_NEXT(a_busy_after_take, pix_valid && pix_ready && !stat.drop, !pix_ready)
	`SGM_ASSERT_IMP(a_frame_end_row_end, res_valid && frame_end, row_end)

endmodule
